// ===== rtl/core/lirs_pkg.sv =====
// Shared types, constants and the microcode ROM for the linear
// interpolation resampler. No dependencies; used by the core and its checker.
package lirs_pkg;

  // Output cap per input sample
  localparam int MAX_OUT  = 8;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 21;
  localparam int PHASE_W  = 22;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + PHASE_W;
  localparam int FRAC_W   = 16;
  localparam int SHIFT_W  = PROD_W - FRAC_W;
  localparam int SUM_W    = SHIFT_W + 1;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);

  // APB register map
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 2;
  localparam logic [ADDR_W-1:0] ADDR_PHASE_STEP = 2'd0;
  localparam logic [STEP_W-1:0] STEP_RESET      = 21'd65536;

  // Q16 phase constants
  localparam logic signed [PHASE_W-1:0] ONE_Q16 = 22'sd65536;
  localparam logic signed [PHASE_W-1:0] PH_MAX  = 22'sd2097151;
  localparam logic signed [PHASE_W-1:0] PH_MIN  = -22'sd2097152;

  // Sample saturation bounds
  localparam logic signed [SUM_W-1:0] SMP_MAX = 24'sd32767;
  localparam logic signed [SUM_W-1:0] SMP_MIN = -24'sd32768;

  // Microprogram counter and step addresses
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] upc_t;
  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_FIRST  = 3'd1;
  localparam upc_t UPC_TEST   = 3'd2;
  localparam upc_t UPC_MUL    = 3'd3;
  localparam upc_t UPC_EMIT   = 3'd4;
  localparam upc_t UPC_FINISH = 3'd5;

  // Datapath operation of one step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_FIRST,
    OP_TEST,
    OP_MUL,
    OP_EMIT,
    OP_FINISH
  } uop_e;

  // Jump condition of one step
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_HAVE_PREV,
    JMP_PH_OVER,
    JMP_MORE
  } cond_e;

  // Control word
  typedef struct packed {
    logic  take_in;  // step waits for an input transfer
    logic  put_out;  // step waits for room in the output register
    uop_e  op;
    cond_e cond;
    upc_t  target;
  } uword_t;

  // Microcode ROM: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{take_in: 1'b1, put_out: 1'b0, op: OP_IDLE, cond: JMP_HAVE_PREV,
          target: UPC_TEST};
    case (pc)
      UPC_WAIT: begin
        w = '{take_in: 1'b1, put_out: 1'b0, op: OP_IDLE, cond: JMP_HAVE_PREV,
              target: UPC_TEST};
      end
      UPC_FIRST: begin
        w = '{take_in: 1'b0, put_out: 1'b1, op: OP_FIRST, cond: JMP_ALWAYS,
              target: UPC_WAIT};
      end
      UPC_TEST: begin
        w = '{take_in: 1'b0, put_out: 1'b0, op: OP_TEST, cond: JMP_PH_OVER,
              target: UPC_FINISH};
      end
      UPC_MUL: begin
        w = '{take_in: 1'b0, put_out: 1'b0, op: OP_MUL, cond: JMP_NEVER,
              target: UPC_EMIT};
      end
      UPC_EMIT: begin
        w = '{take_in: 1'b0, put_out: 1'b1, op: OP_EMIT, cond: JMP_MORE,
              target: UPC_MUL};
      end
      UPC_FINISH: begin
        w = '{take_in: 1'b0, put_out: 1'b0, op: OP_FINISH, cond: JMP_ALWAYS,
              target: UPC_WAIT};
      end
      default: begin
        w = '{take_in: 1'b0, put_out: 1'b0, op: OP_IDLE, cond: JMP_ALWAYS,
              target: UPC_WAIT};
      end
    endcase
    return w;
  endfunction

  // Clamp a widened phase back into the signed 22-bit range
  function automatic logic signed [PHASE_W-1:0] sat_phase(
    logic signed [PHASE_W:0] v
  );
    logic signed [PHASE_W-1:0] r;
    if (v > $signed({PH_MAX[PHASE_W-1], PH_MAX})) begin
      r = PH_MAX;
    end else if (v < $signed({PH_MIN[PHASE_W-1], PH_MIN})) begin
      r = PH_MIN;
    end else begin
      r = v[PHASE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/linear_interp_resampler_unit.sv =====
// Linear interpolation resampler, top level: microcoded sequencer, one
// shared multiplier, output register and APB register. Depends on lirs_pkg.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_ready_o  in_sample_i
//  out      source     out_valid_o / out_ready_i out_sample_o, last_o
//  apb      slave      psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// First sample after reset: an accept step, then a pass-through step.
// Other samples: accept and test steps, then per output a multiply step and
// an emit step around the single registered multiplier, then a finish step.
// The output register lets the sequencer go on while a result waits;
// an emit step stalls while that register is full and not taken.
// Reset (rst_ni, async, active low) clears the sequencer, phase and history.
module linear_interp_resampler_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input samples
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0]   in_sample_i,
  // output samples
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lirs_pkg::SAMPLE_W-1:0]   out_sample_o,
  output logic                                   last_o,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lirs_pkg::ADDR_W-1:0]            paddr,
  input  logic [lirs_pkg::DATA_W-1:0]            pwdata,
  output logic [lirs_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int SW = lirs_pkg::SAMPLE_W;
  localparam int PW = lirs_pkg::PHASE_W;

  // Registers
  lirs_pkg::upc_t                     pc_q, pc_d;
  logic [lirs_pkg::STEP_W-1:0]        step_q;
  logic                               have_prev_q;
  logic signed [SW-1:0]               prev_q;
  logic signed [SW-1:0]               cur_q;
  logic signed [PW-1:0]               phase_q;
  logic signed [lirs_pkg::PROD_W-1:0] prod_q;
  logic [lirs_pkg::CNT_W-1:0]         n_q;
  logic                               out_valid_q;
  logic signed [SW-1:0]               out_sample_q;
  logic                               out_last_q;

  // Control word and step handshake
  lirs_pkg::uword_t uw;
  logic             out_free;
  logic             fire;
  logic             jump;

  // Datapath
  logic signed [PW:0]                  ph_wide;
  logic signed [PW-1:0]                ph_inc;
  logic signed [PW-1:0]                ph_dec;
  logic signed [lirs_pkg::DIFF_W-1:0]  diff;
  logic signed [lirs_pkg::PROD_W-1:0]  prod_d;
  logic signed [lirs_pkg::SHIFT_W-1:0] prod_sh;
  logic signed [lirs_pkg::SUM_W-1:0]   sum;
  logic signed [SW-1:0]                interp;
  logic                                more;
  logic                                cfg_wr;

  assign uw       = lirs_pkg::ucode_rom(pc_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = !((uw.take_in && !in_valid_i) || (uw.put_out && !out_free));

  // Phase update: add step or subtract one period, saturated
  assign ph_wide = {phase_q[PW-1], phase_q};
  assign ph_inc  = lirs_pkg::sat_phase(ph_wide + $signed({2'b00, step_q}));
  assign ph_dec  = lirs_pkg::sat_phase(ph_wide - $signed({lirs_pkg::ONE_Q16[PW-1],
                                                          lirs_pkg::ONE_Q16}));

  // Interpolation: multiply, then floor shift, add and saturate
  assign diff    = $signed({cur_q[SW-1], cur_q}) - $signed({prev_q[SW-1], prev_q});
  assign prod_d  = lirs_pkg::PROD_W'(diff) * lirs_pkg::PROD_W'(phase_q);
  assign prod_sh = prod_q[lirs_pkg::PROD_W-1:lirs_pkg::FRAC_W];
  assign sum     = $signed({prod_sh[lirs_pkg::SHIFT_W-1], prod_sh})
                 + lirs_pkg::SUM_W'(prev_q);

  always_comb begin
    if (sum > lirs_pkg::SMP_MAX) begin
      interp = lirs_pkg::SMP_MAX[SW-1:0];
    end else if (sum < lirs_pkg::SMP_MIN) begin
      interp = lirs_pkg::SMP_MIN[SW-1:0];
    end else begin
      interp = sum[SW-1:0];
    end
  end

  // Another output follows unless the phase passes one period or the cap is hit
  assign more = (ph_inc <= lirs_pkg::ONE_Q16)
             && (n_q != lirs_pkg::CNT_W'(lirs_pkg::MAX_OUT - 1));

  // Sequencer jump logic
  always_comb begin
    case (uw.cond)
      lirs_pkg::JMP_NEVER:     jump = 1'b0;
      lirs_pkg::JMP_ALWAYS:    jump = 1'b1;
      lirs_pkg::JMP_HAVE_PREV: jump = have_prev_q;
      lirs_pkg::JMP_PH_OVER:   jump = phase_q > lirs_pkg::ONE_Q16;
      lirs_pkg::JMP_MORE:      jump = more;
      default:                 jump = 1'b0;
    endcase
    if (!fire) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + lirs_pkg::upc_t'(1);
    end
  end

  assign cfg_wr = psel && penable && pwrite && (paddr == lirs_pkg::ADDR_PHASE_STEP);

  // Control state and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= lirs_pkg::UPC_WAIT;
      step_q      <= lirs_pkg::STEP_RESET;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_wr) begin
        step_q <= pwdata[lirs_pkg::STEP_W-1:0];
      end
      if (fire && (uw.op == lirs_pkg::OP_FIRST)) begin
        have_prev_q <= 1'b1;
        prev_q      <= cur_q;
        phase_q     <= ph_inc;
      end
      if (fire && (uw.op == lirs_pkg::OP_EMIT)) begin
        phase_q <= ph_inc;
      end
      if (fire && (uw.op == lirs_pkg::OP_FINISH)) begin
        phase_q <= ph_dec;
        prev_q  <= cur_q;
      end
      if (fire && uw.put_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: current sample, product, output count, output data
  always_ff @(posedge clk_i) begin
    if (fire && (uw.op == lirs_pkg::OP_IDLE)) begin
      cur_q <= in_sample_i;
    end
    if (fire && (uw.op == lirs_pkg::OP_MUL)) begin
      prod_q <= prod_d;
    end
    if (fire && (uw.op == lirs_pkg::OP_TEST)) begin
      n_q <= '0;
    end else if (fire && (uw.op == lirs_pkg::OP_EMIT)) begin
      n_q <= n_q + lirs_pkg::CNT_W'(1);
    end
    if (fire && (uw.op == lirs_pkg::OP_FIRST)) begin
      out_sample_q <= cur_q;
      out_last_q   <= 1'b1;
    end else if (fire && (uw.op == lirs_pkg::OP_EMIT)) begin
      out_sample_q <= interp;
      out_last_q   <= !more;
    end
  end

  // Ports
  assign in_ready_o   = uw.take_in;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign last_o       = out_last_q;
  assign pready       = 1'b1;
  assign prdata       = (paddr == lirs_pkg::ADDR_PHASE_STEP)
                      ? lirs_pkg::DATA_W'(step_q) : '0;

endmodule

// ===== rtl/core/lirs_checker.sv =====
// Port-level checker for the resampler top level, bound to it below.
// Depends on lirs_pkg and linear_interp_resampler_unit.
module lirs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [lirs_pkg::SAMPLE_W-1:0] out_sample_o,
  input logic                                 last_o,
  input logic                                 pready
);

  // APB never inserts wait states
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  // The sequencer is busy in the cycle after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // A new result only comes from a busy sequencer step
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while sequencer was idle");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_sample_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (.*);

// ===== tb/linear_interp_resampler_unit_tb.sv =====
// Self-checking testbench for linear_interp_resampler_unit: drives PCM samples
// through valid/ready, programs phase_step over APB and scores every output.
// Depends on lirs_pkg and the resampler RTL only.
`timescale 1ns / 100ps

module linear_interp_resampler_unit_tb;

  typedef logic signed [lirs_pkg::SAMPLE_W-1:0] pcm_t;
  typedef logic signed [lirs_pkg::PHASE_W-1:0]  phase_t;
  typedef logic [lirs_pkg::STEP_W-1:0]          step_t;

  // One output transfer as the scoreboard sees it
  typedef struct packed {
    pcm_t smp;
    logic last;
  } resamp_out_t;

  // Directed row: optional step write before the sample, optional literal result
  typedef struct packed {
    logic  wr;
    step_t step;
    pcm_t  smp;
    logic  typed;
    pcm_t  typed_smp;
  } dir_row_t;

  localparam int SETTLE_CYCLES = 40;     // longest sequence for one input plus output register, padded
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEG_ITEMS     = 40;
  localparam int SEG_N         = 8;
  localparam int DIR_N         = 17;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  pcm_t                        in_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  pcm_t                        out_sample_o;
  logic                        last_o;
  logic                        psel        = 1'b0;
  logic                        penable     = 1'b0;
  logic                        pwrite      = 1'b0;
  logic [lirs_pkg::ADDR_W-1:0] paddr       = '0;
  logic [lirs_pkg::DATA_W-1:0] pwdata      = '0;
  logic [lirs_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  linear_interp_resampler_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state, mirrors the block
  logic        have_prev_m = 1'b0;
  pcm_t        prev_m      = '0;
  phase_t      phase_m     = '0;
  step_t       step_m      = lirs_pkg::STEP_RESET;
  resamp_out_t burst_a [lirs_pkg::MAX_OUT];

  resamp_out_t expected_q [$];
  pcm_t        last_smp      = '0;
  int          fail_cnt      = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          step_writes   = 0;
  int          cycle_cnt     = 0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  int          hold_left     = 0;
  bit          hold_request  = 1'b0;
  resamp_out_t got_exp;

  dir_row_t dir_tab [DIR_N] = '{
    // step 1.0 from reset: first sample passes, then each output equals the input
    '{1'b0, 21'd0,       16'sh7FFF,    1'b1, 16'sh7FFF},
    '{1'b0, 21'd0,       16'sh8000,    1'b1, 16'sh8000},
    '{1'b0, 21'd0,       16'sd0,       1'b1, 16'sd0},
    '{1'b0, 21'd0,       16'sd21845,   1'b1, 16'sd21845},
    '{1'b0, 21'd0,      -16'sd21846,   1'b1, -16'sd21846},
    // half step, rounding toward minus infinity
    '{1'b1, 21'd32768,   16'sd0,       1'b0, 16'sd0},
    '{1'b0, 21'd0,      -16'sd1,       1'b0, 16'sd0},
    '{1'b0, 21'd0,       16'sd1,       1'b0, 16'sd0},
    // smallest legal step
    '{1'b1, 21'd8192,    16'sh7FFF,    1'b0, 16'sd0},
    '{1'b0, 21'd0,       16'sh8000,    1'b0, 16'sd0},
    // step under range: output cap drops outputs, phase goes negative
    '{1'b1, 21'd4096,    16'sd100,     1'b0, 16'sd0},
    // zero step: extrapolation, sample saturation both ways
    '{1'b1, 21'd0,       16'sh7FFF,    1'b0, 16'sd0},
    '{1'b0, 21'd0,       16'sh8000,    1'b0, 16'sd0},
    '{1'b0, 21'd0,       16'sh7FFF,    1'b0, 16'sd0},
    // all-ones step, then largest legal step: inputs with no output
    '{1'b1, 21'h1FFFFF,  16'sd0,       1'b0, 16'sd0},
    '{1'b0, 21'd0,       16'sd5,       1'b0, 16'sd0},
    '{1'b1, 21'd1048576, -16'sd7,      1'b0, 16'sd0}
  };

  // Saturate to the signed 22-bit phase range
  function automatic phase_t clamp_phase(input longint v);
    if (v > longint'(lirs_pkg::PH_MAX)) return lirs_pkg::PH_MAX;
    if (v < longint'(lirs_pkg::PH_MIN)) return lirs_pkg::PH_MIN;
    return v[lirs_pkg::PHASE_W-1:0];
  endfunction

  // prev + floor((cur - prev) * phase / 2^16), saturated to 16 bits
  function automatic pcm_t lerp_sample(input pcm_t a, input pcm_t b, input phase_t ph);
    longint prod;
    longint r;
    prod = (longint'(b) - longint'(a)) * longint'(ph);
    r = longint'(a) + (prod >>> 16);
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[lirs_pkg::SAMPLE_W-1:0];
  endfunction

  // Advance the predictor by one input; fills burst_a, returns the output count
  function automatic int resample_model(input pcm_t cur);
    int n;
    n = 0;
    if (!have_prev_m) begin
      have_prev_m = 1'b1;
      prev_m      = cur;
      phase_m     = clamp_phase(longint'(phase_m) + longint'(step_m));
      burst_a[0]  = '{cur, 1'b1};
      return 1;
    end
    while (phase_m <= lirs_pkg::ONE_Q16 && n < lirs_pkg::MAX_OUT) begin
      burst_a[n] = '{lerp_sample(prev_m, cur, phase_m), 1'b0};
      n++;
      phase_m = clamp_phase(longint'(phase_m) + longint'(step_m));
    end
    phase_m = clamp_phase(longint'(phase_m) - longint'(lirs_pkg::ONE_Q16));
    prev_m  = cur;
    if (n > 0) burst_a[n-1].last = 1'b1;
    return n;
  endfunction

  // Random sample: mostly full range, some extremes, some near the last one
  function automatic pcm_t next_sample();
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(99);
    r    = $urandom;
    if (pick < 60) return r[lirs_pkg::SAMPLE_W-1:0];
    if (pick < 75) begin
      case (r[1:0])
        2'd0:    return 16'sh7FFF;
        2'd1:    return 16'sh8000;
        2'd2:    return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    return last_smp + pcm_t'($signed(r[9:0]));
  endfunction

  // Step for each random segment; extremes sit in fixed segments
  function automatic step_t pick_step(input int seg);
    case (seg)
      0:       return step_t'($urandom_range(131072, 8192));
      1:       return 21'd8192;
      2:       return step_t'($urandom_range(1048576, 8192));
      3:       return 21'd1048576;
      4:       return 21'd0;
      5:       return 21'h1FFFFF;
      6:       return step_t'($urandom_range(2097151, 0));
      default: return step_t'($urandom_range(262144, 16384));
    endcase
  endfunction

  // One input transfer with random idle cycles in front of it
  task automatic send_sample(input pcm_t smp, input logic typed, input pcm_t typed_smp);
    int n;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    n = resample_model(smp);
    if (typed) begin
      expected_q.push_back('{typed_smp, 1'b1});
    end else begin
      for (int i = 0; i < n; i++) expected_q.push_back(burst_a[i]);
    end
    last_smp = smp;
    items_sent++;
  endtask

  // Let the block drain: all results in, then its own latency
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of phase_step, then read it back
  task automatic program_step(input step_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lirs_pkg::ADDR_PHASE_STEP;
    pwdata  <= lirs_pkg::DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    step_m = v;
    step_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[lirs_pkg::STEP_W-1:0] !== v) begin
      $error("phase_step: expected %0d, got %0d", v, prdata[lirs_pkg::STEP_W-1:0]);
      fail_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side: score each transfer, randomize ready, long hold on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected output: out_sample %0d, last %0b", out_sample_o, last_o);
        fail_cnt++;
      end else begin
        got_exp = expected_q.pop_front();
        if (out_sample_o !== got_exp.smp) begin
          $error("out_sample: expected %0d, got %0d", got_exp.smp, out_sample_o);
          fail_cnt++;
        end
        if (last_o !== got_exp.last) begin
          $error("last: expected %0b, got %0b", got_exp.last, last_o);
          fail_cnt++;
        end
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    tx_idle_pct = 12;
    rx_idle_pct = 86;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr) begin
        settle();
        program_step(dir_tab[i].step);
      end
      send_sample(dir_tab[i].smp, dir_tab[i].typed, dir_tab[i].typed_smp);
    end

    // random part, one step setting per segment
    for (int seg = 0; seg < SEG_N; seg++) begin
      if (seg == 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 12;
      end else if (seg == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      settle();
      program_step(pick_step(seg));
      // smallest step fills the block: stall the output while inputs keep coming
      if (seg == 1) hold_request = 1'b1;
      for (int k = 0; k < SEG_ITEMS; k++) send_sample(next_sample(), 1'b0, '0);
    end

    settle();
    $display("Run covered %0d input samples, %0d output samples, %0d phase_step writes.",
             items_sent, results_seen, step_writes);
    $display("Steps from zero to all ones, output cap, silent inputs, saturation, long stall.");
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
